/* hw/rtl/arm_pv_pkg.sv */
package arm_pv_pkg;

  localparam int ANGLE_BITS    = 16;
  localparam int RATE_BITS     = 16;
  localparam int VELOCITY_BITS = 24;
  localparam int TRIG_BITS     = 16;
  localparam int LEN_BITS      = 24;
  localparam int POINT_BITS    = 3;

  // last point of a run (the tool)
  localparam logic [POINT_BITS-1:0] POINT_TOOL = 3'd6;

  // quarter turn in binary angle units
  localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

  // sine polynomial coefficients, Q30
  localparam logic [31:0] SIN_C1 = 32'd1686629713;
  localparam logic [31:0] SIN_C3 = 32'd693598668;
  localparam logic [31:0] SIN_C5 = 32'd85569305;
  localparam logic [31:0] SIN_C7 = 32'd5026995;
  localparam logic [31:0] SIN_C9 = 32'd172272;

  // link lengths, Q24 metres
  localparam logic signed [LEN_BITS-1:0] LEN_0679  = 24'sd1139173;
  localparam logic signed [LEN_BITS-1:0] LEN_13585 = 24'sd2279185;
  localparam logic signed [LEN_BITS-1:0] LEN_2125  = 24'sd3565158;
  localparam logic signed [LEN_BITS-1:0] LEN_425   = 24'sd7130317;
  localparam logic signed [LEN_BITS-1:0] LEN_08405 = 24'sd1410125;
  localparam logic signed [LEN_BITS-1:0] LEN_01615 = 24'sd270952;
  localparam logic signed [LEN_BITS-1:0] LEN_1294  = 24'sd2170972;
  localparam logic signed [LEN_BITS-1:0] LEN_2589  = 24'sd4343621;
  localparam logic signed [LEN_BITS-1:0] LEN_39225 = 24'sd6580863;
  localparam logic signed [LEN_BITS-1:0] LEN_06265 = 24'sd1051093;
  localparam logic signed [LEN_BITS-1:0] LEN_10915 = 24'sd1831233;
  localparam logic signed [LEN_BITS-1:0] LEN_0411  = 24'sd689544;
  localparam logic signed [LEN_BITS-1:0] LEN_09465 = 24'sd1587963;

  typedef logic signed [TRIG_BITS-1:0] trig_t;
  typedef logic signed [RATE_BITS-1:0] rate_t;

  // one joint sample after the trig stage
  typedef struct packed {
    trig_t s1, c1, s2, c2, sa, ca, sb, cb, s5, c5;
    trig_t cb_s5, sb_s5, cb_c5, sb_c5;
    rate_t u1, u2, u5;
    logic signed [RATE_BITS:0]   w23;
    logic signed [RATE_BITS+1:0] w234;
  } item_t;

  typedef struct packed {
    logic signed [LEN_BITS-1:0] la;
    logic signed [LEN_BITS-1:0] lb;
    logic signed [LEN_BITS-1:0] sd;
  } len_t;

  // reach and side lengths of each point
  function automatic len_t point_len(input logic [POINT_BITS-1:0] k);
    len_t l;
    l = '{la: '0, lb: '0, sd: LEN_0679};
    case (k)
      3'd0: l = '{la: '0,      lb: '0,        sd: LEN_0679};
      3'd1: l = '{la: LEN_2125, lb: '0,       sd: LEN_13585};
      3'd2: l = '{la: LEN_425, lb: '0,        sd: LEN_08405};
      3'd3: l = '{la: LEN_425, lb: LEN_1294,  sd: LEN_01615};
      3'd4: l = '{la: LEN_425, lb: LEN_2589,  sd: LEN_01615};
      3'd5: l = '{la: LEN_425, lb: LEN_39225, sd: LEN_06265};
      3'd6: l = '{la: LEN_425, lb: LEN_39225, sd: LEN_10915};
      default: l = '{la: '0, lb: '0, sd: LEN_0679};
    endcase
    return l;
  endfunction

  // shift right, rounding half towards plus infinity
  function automatic logic signed [63:0] rnd(input logic signed [63:0] v,
                                             input int unsigned s);
    logic signed [63:0] t;
    t = v + (64'sd1 <<< (s - 1));
    return t >>> s;
  endfunction

  // clamp to the signed velocity range
  function automatic logic signed [VELOCITY_BITS-1:0] sat_vel(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (VELOCITY_BITS - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) begin
      return hi[VELOCITY_BITS-1:0];
    end else if (v < lo) begin
      return lo[VELOCITY_BITS-1:0];
    end
    return v[VELOCITY_BITS-1:0];
  endfunction

endpackage

/* hw/rtl/arm_point_velocities.sv */
// Point velocities of a six-axis arm. Pulse start with five joint angles and
// rates while busy is low; after the trig and point pipelines the block
// emits seven words, points 0 (base) to 6 (tool), one per cycle on valid_o,
// with last_point_o on the tool word. Results cannot be held off: the
// receiver must take every word in the cycle it appears. A new sample is
// accepted only once busy has fallen, so the single point pipeline emits a
// whole run before the next begins; busy goes high after each accepted sample.
module arm_point_velocities (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          start,
  output logic                                          busy,
  input  logic signed [arm_pv_pkg::ANGLE_BITS-1:0]      angle_1_i,
  input  logic signed [arm_pv_pkg::ANGLE_BITS-1:0]      angle_2_i,
  input  logic signed [arm_pv_pkg::ANGLE_BITS-1:0]      angle_3_i,
  input  logic signed [arm_pv_pkg::ANGLE_BITS-1:0]      angle_4_i,
  input  logic signed [arm_pv_pkg::ANGLE_BITS-1:0]      angle_5_i,
  input  logic signed [arm_pv_pkg::RATE_BITS-1:0]       rate_1_i,
  input  logic signed [arm_pv_pkg::RATE_BITS-1:0]       rate_2_i,
  input  logic signed [arm_pv_pkg::RATE_BITS-1:0]       rate_3_i,
  input  logic signed [arm_pv_pkg::RATE_BITS-1:0]       rate_4_i,
  input  logic signed [arm_pv_pkg::RATE_BITS-1:0]       rate_5_i,
  output logic                                          valid_o,
  output logic [arm_pv_pkg::POINT_BITS-1:0]             point_index_o,
  output logic signed [arm_pv_pkg::VELOCITY_BITS-1:0]   vel_x_o,
  output logic signed [arm_pv_pkg::VELOCITY_BITS-1:0]   vel_y_o,
  output logic signed [arm_pv_pkg::VELOCITY_BITS-1:0]   vel_z_o,
  output logic                                          last_point_o
);

  localparam int NTRIG = 10;
  localparam int SLAT  = 8;
  localparam int AB    = arm_pv_pkg::ANGLE_BITS;

  logic       accept;
  logic [2:0] gap_q;
  logic       v0_q;
  logic       vs_q [SLAT];
  logic [AB-1:0] ang_q [NTRIG];
  arm_pv_pkg::trig_t trig [NTRIG];
  arm_pv_pkg::rate_t u1_q [SLAT+1], u2_q [SLAT+1], u5_q [SLAT+1];
  logic signed [arm_pv_pkg::RATE_BITS:0]   w23_q  [SLAT+1];
  logic signed [arm_pv_pkg::RATE_BITS+1:0] w234_q [SLAT+1];
  logic [AB-1:0] a23, a234;
  arm_pv_pkg::item_t item_q;
  logic       run_q;
  logic [arm_pv_pkg::POINT_BITS-1:0] k_q;
  logic signed [31:0] p_cs, p_ss, p_cc, p_sc;

  assign accept = start && !busy;
  assign busy   = (gap_q != 3'd0);

  // hold off new samples after each accepted one so that runs do not overlap
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= 3'd0;
    end else if (accept) begin
      gap_q <= 3'd6;
    end else if (gap_q != 3'd0) begin
      gap_q <= gap_q - 3'd1;
    end
  end

  always_comb begin
    a23  = angle_2_i + angle_3_i;
    a234 = a23 + angle_4_i;
  end

  // capture the sample: sine then cosine angles
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ang_q[0] <= angle_1_i;
      ang_q[1] <= angle_1_i + arm_pv_pkg::QUARTER_TURN;
      ang_q[2] <= angle_2_i;
      ang_q[3] <= angle_2_i + arm_pv_pkg::QUARTER_TURN;
      ang_q[4] <= a23;
      ang_q[5] <= a23 + arm_pv_pkg::QUARTER_TURN;
      ang_q[6] <= a234;
      ang_q[7] <= a234 + arm_pv_pkg::QUARTER_TURN;
      ang_q[8] <= angle_5_i;
      ang_q[9] <= angle_5_i + arm_pv_pkg::QUARTER_TURN;
      u1_q[0]   <= rate_1_i;
      u2_q[0]   <= rate_2_i;
      u5_q[0]   <= rate_5_i;
      w23_q[0]  <= 17'(rate_2_i) + 17'(rate_3_i);
      w234_q[0] <= 18'(rate_2_i) + 18'(rate_3_i) + 18'(rate_4_i);
    end
    for (int i = 1; i <= SLAT; i++) begin
      u1_q[i]   <= u1_q[i-1];
      u2_q[i]   <= u2_q[i-1];
      u5_q[i]   <= u5_q[i-1];
      w23_q[i]  <= w23_q[i-1];
      w234_q[i] <= w234_q[i-1];
    end
  end

  for (genvar g = 0; g < NTRIG; g++) begin : g_trig
    arm_pv_sin u_sin (
      .clk_i   (clk_i),
      .angle_i (ang_q[g]),
      .sin_o   (trig[g])
    );
  end

  // valid bits along the trig pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      for (int i = 0; i < SLAT; i++) vs_q[i] <= 1'b0;
    end else begin
      v0_q    <= accept;
      vs_q[0] <= v0_q;
      for (int i = 1; i < SLAT; i++) vs_q[i] <= vs_q[i-1];
    end
  end

  // products of wrist trig values
  always_comb begin
    p_cs = trig[7] * trig[8];
    p_ss = trig[6] * trig[8];
    p_cc = trig[7] * trig[9];
    p_sc = trig[6] * trig[9];
  end

  // load the item register that feeds the point sequencer
  always_ff @(posedge clk_i) begin
    if (vs_q[SLAT-1]) begin
      item_q.s1    <= trig[0];
      item_q.c1    <= trig[1];
      item_q.s2    <= trig[2];
      item_q.c2    <= trig[3];
      item_q.sa    <= trig[4];
      item_q.ca    <= trig[5];
      item_q.sb    <= trig[6];
      item_q.cb    <= trig[7];
      item_q.s5    <= trig[8];
      item_q.c5    <= trig[9];
      item_q.cb_s5 <= 16'((p_cs + 32'sd8192) >>> 14);
      item_q.sb_s5 <= 16'((p_ss + 32'sd8192) >>> 14);
      item_q.cb_c5 <= 16'((p_cc + 32'sd8192) >>> 14);
      item_q.sb_c5 <= 16'((p_sc + 32'sd8192) >>> 14);
      item_q.u1    <= u1_q[SLAT];
      item_q.u2    <= u2_q[SLAT];
      item_q.u5    <= u5_q[SLAT];
      item_q.w23   <= w23_q[SLAT];
      item_q.w234  <= w234_q[SLAT];
    end
  end

  // step through the seven points
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      k_q   <= '0;
    end else if (vs_q[SLAT-1]) begin
      run_q <= 1'b1;
      k_q   <= '0;
    end else if (run_q) begin
      if (k_q == arm_pv_pkg::POINT_TOOL) begin
        run_q <= 1'b0;
      end else begin
        k_q <= k_q + 3'd1;
      end
    end
  end

  arm_pv_point u_point (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (run_q),
    .k_i           (k_q),
    .item_i        (item_q),
    .valid_o       (valid_o),
    .point_index_o (point_index_o),
    .vel_x_o       (vel_x_o),
    .vel_y_o       (vel_y_o),
    .vel_z_o       (vel_z_o),
    .last_point_o  (last_point_o)
  );

endmodule

/* hw/rtl/arm_pv_sin.sv */
module arm_pv_sin (
  input  logic                                  clk_i,
  input  logic [arm_pv_pkg::ANGLE_BITS-1:0]     angle_i,
  output arm_pv_pkg::trig_t                     sin_o
);

  localparam int NS = 7;
  localparam logic [30:0] ONE = 31'd1 << 30;

  logic [30:0] x_q  [NS-1];
  logic [1:0]  qd_q [NS];
  logic [30:0] x2_q [1:4];
  logic [31:0] s_q  [2:5];
  logic [31:0] phase;
  logic [30:0] f, x_d;
  logic [63:0] px2, pv;
  logic [63:0] ph [4];
  logic [31:0] hs [4];
  logic [30:0] v_d;
  logic [14:0] r_d;
  logic [14:0] r_q;
  logic signed [arm_pv_pkg::TRIG_BITS-1:0] sin_q;

  // fold the phase into the first quadrant
  always_comb begin
    phase = {angle_i, {(32 - arm_pv_pkg::ANGLE_BITS){1'b0}}};
    f     = {1'b0, phase[29:0]};
    x_d   = phase[30] ? (ONE - f) : f;
  end

  // square of x; final product, clamp and round to Q14
  always_comb begin
    px2 = 64'(x_q[0]) * 64'(x_q[0]);
    pv  = 64'(x_q[5]) * 64'(s_q[5]);
    v_d = (pv[63:30] > 34'(ONE)) ? ONE : pv[60:30];
    r_d = 15'((v_d + 31'd32768) >> 16);
  end

  // Horner step: coefficient minus x^2 times the running sum
  always_comb begin
    ph[0] = 64'(x2_q[1]) * 64'(arm_pv_pkg::SIN_C9);
    hs[0] = arm_pv_pkg::SIN_C7 - ph[0][61:30];
    ph[1] = 64'(x2_q[2]) * 64'(s_q[2]);
    hs[1] = arm_pv_pkg::SIN_C5 - ph[1][61:30];
    ph[2] = 64'(x2_q[3]) * 64'(s_q[3]);
    hs[2] = arm_pv_pkg::SIN_C3 - ph[2][61:30];
    ph[3] = 64'(x2_q[4]) * 64'(s_q[4]);
    hs[3] = arm_pv_pkg::SIN_C1 - ph[3][61:30];
  end

  // advance the polynomial one step per stage
  always_ff @(posedge clk_i) begin
    x_q[0]  <= x_d;
    qd_q[0] <= phase[31:30];
    for (int i = 1; i < NS - 1; i++) begin
      x_q[i] <= x_q[i-1];
    end
    for (int i = 1; i < NS; i++) begin
      qd_q[i] <= qd_q[i-1];
    end
    x2_q[1] <= px2[60:30];
    for (int i = 2; i <= 4; i++) begin
      x2_q[i] <= x2_q[i-1];
    end
    s_q[2]  <= hs[0];
    s_q[3]  <= hs[1];
    s_q[4]  <= hs[2];
    s_q[5]  <= hs[3];
    r_q     <= r_d;
    sin_q   <= qd_q[6][1] ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
  end

  assign sin_o = sin_q;

endmodule

/* hw/rtl/arm_pv_point.sv */
module arm_pv_point (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          valid_i,
  input  logic [arm_pv_pkg::POINT_BITS-1:0]             k_i,
  input  arm_pv_pkg::item_t                             item_i,
  output logic                                          valid_o,
  output logic [arm_pv_pkg::POINT_BITS-1:0]             point_index_o,
  output logic signed [arm_pv_pkg::VELOCITY_BITS-1:0]   vel_x_o,
  output logic signed [arm_pv_pkg::VELOCITY_BITS-1:0]   vel_y_o,
  output logic signed [arm_pv_pkg::VELOCITY_BITS-1:0]   vel_z_o,
  output logic                                          last_point_o
);

  localparam int NST = 7;

  typedef struct packed {
    logic [arm_pv_pkg::POINT_BITS-1:0] k;
    arm_pv_pkg::rate_t u1, u2, u5;
    logic signed [arm_pv_pkg::RATE_BITS:0]   w23;
    logic signed [arm_pv_pkg::RATE_BITS+1:0] w234;
    arm_pv_pkg::trig_t s1, c1;
    logic signed [arm_pv_pkg::LEN_BITS-1:0] sd;
  } carry_t;

  logic   v_q [NST];
  carry_t c_q [NST];

  arm_pv_pkg::len_t len;
  logic signed [arm_pv_pkg::LEN_BITS-1:0] l9, l4;
  logic signed [39:0] a_q, b_q, c2_q, d_q, e_q, f_q, g_q, h_q, i_q, j_q, kk_q, m_q;
  logic signed [63:0] pa_q, pb_q, pc_q, pd_q, pe_q, pf_q, pg_q, ph_q, pi_q, pj_q, pk_q;
  logic signed [63:0] r38_q, d38_q, dr_q, dd_q, dz_q, r30_q, d30_q;
  logic signed [63:0] m1_q, m2_q, drr_q, ddr_q, a30_q, b30_q;
  logic signed [63:0] mxa_q, mxb_q, mya_q, myb_q;
  logic signed [arm_pv_pkg::VELOCITY_BITS-1:0] vz_q [3];
  carry_t c_in;

  always_comb begin
    len  = arm_pv_pkg::point_len(k_i);
    l9   = (k_i == arm_pv_pkg::POINT_TOOL) ? arm_pv_pkg::LEN_09465 : '0;
    l4   = (k_i == arm_pv_pkg::POINT_TOOL) ? arm_pv_pkg::LEN_0411 : '0;
    c_in = '{k: k_i, u1: item_i.u1, u2: item_i.u2, u5: item_i.u5, w23: item_i.w23,
             w234: item_i.w234, s1: item_i.s1, c1: item_i.c1, sd: len.sd};
  end

  // valid bits travel with the words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NST; i++) v_q[i] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
      for (int i = 1; i < NST; i++) v_q[i] <= v_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    c_q[0] <= c_in;
    for (int i = 1; i < NST; i++) c_q[i] <= c_q[i-1];

    // length times trig
    a_q  <= len.la * item_i.c2;
    b_q  <= len.lb * item_i.ca;
    c2_q <= len.la * item_i.s2;
    d_q  <= len.lb * item_i.sa;
    e_q  <= l9 * item_i.sb;
    f_q  <= l4 * item_i.cb_s5;
    g_q  <= l9 * item_i.cb;
    h_q  <= l4 * item_i.sb_s5;
    i_q  <= l4 * item_i.cb_c5;
    j_q  <= l4 * item_i.s5;
    kk_q <= l4 * item_i.sb_c5;
    m_q  <= l4 * item_i.c5;

    // times joint rates; reach and offset sums
    pa_q  <= a_q  * c_q[0].u2;
    pb_q  <= b_q  * c_q[0].w23;
    pc_q  <= c2_q * c_q[0].u2;
    pd_q  <= d_q  * c_q[0].w23;
    pe_q  <= e_q  * c_q[0].w234;
    pf_q  <= f_q  * c_q[0].w234;
    pg_q  <= g_q  * c_q[0].w234;
    ph_q  <= h_q  * c_q[0].w234;
    pi_q  <= i_q  * c_q[0].u5;
    pj_q  <= j_q  * c_q[0].u5;
    pk_q  <= kk_q * c_q[0].u5;
    r38_q <= 64'(a_q) + 64'(b_q) - 64'(e_q) + 64'(f_q);
    d38_q <= (64'(c_q[0].sd) <<< 14) + 64'(m_q);

    // derivative sums, round reach and offset
    dr_q  <= -pc_q - pd_q - pg_q - ph_q + pi_q;
    dd_q  <= -pj_q;
    dz_q  <= -pa_q - pb_q + pe_q - pf_q - pk_q;
    r30_q <= arm_pv_pkg::rnd(r38_q, 8);
    d30_q <= arm_pv_pkg::rnd(d38_q, 8);

    // base rate cross terms
    m1_q   <= 64'(c_q[2].u1) * d30_q;
    m2_q   <= 64'(c_q[2].u1) * r30_q;
    drr_q  <= arm_pv_pkg::rnd(dr_q, 20);
    ddr_q  <= arm_pv_pkg::rnd(dd_q, 20);
    vz_q[0] <= arm_pv_pkg::sat_vel(arm_pv_pkg::rnd(dz_q, 34));

    a30_q   <= drr_q - arm_pv_pkg::rnd(m1_q, 12);
    b30_q   <= ddr_q + arm_pv_pkg::rnd(m2_q, 12);
    vz_q[1] <= vz_q[0];

    // rotate by joint 1
    mxa_q   <= 64'(c_q[4].c1) * a30_q;
    mxb_q   <= 64'(c_q[4].s1) * b30_q;
    mya_q   <= 64'(c_q[4].s1) * a30_q;
    myb_q   <= 64'(c_q[4].c1) * b30_q;
    vz_q[2] <= vz_q[1];

    vel_x_o       <= arm_pv_pkg::sat_vel(arm_pv_pkg::rnd(mxa_q - mxb_q, 28));
    vel_y_o       <= arm_pv_pkg::sat_vel(arm_pv_pkg::rnd(mya_q + myb_q, 28));
    vel_z_o       <= vz_q[2];
    point_index_o <= c_q[5].k;
    last_point_o  <= (c_q[5].k == arm_pv_pkg::POINT_TOOL);
  end

  assign valid_o = v_q[NST-1];

endmodule

/* tb/arm_point_velocities_test.sv */
module arm_point_velocities_test;

  localparam int CYCLE_LIMIT = 200000;
  localparam int N_RANDOM    = 400;

  typedef struct {
    logic [arm_pv_pkg::POINT_BITS-1:0]           point;
    logic signed [arm_pv_pkg::VELOCITY_BITS-1:0] vx;
    logic signed [arm_pv_pkg::VELOCITY_BITS-1:0] vy;
    logic signed [arm_pv_pkg::VELOCITY_BITS-1:0] vz;
    logic                                        last;
  } point_vel_t;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  logic signed [arm_pv_pkg::ANGLE_BITS-1:0] angle_1_i, angle_2_i, angle_3_i, angle_4_i,
                                            angle_5_i;
  logic signed [arm_pv_pkg::RATE_BITS-1:0]  rate_1_i, rate_2_i, rate_3_i, rate_4_i, rate_5_i;
  logic                                        valid_o;
  logic [arm_pv_pkg::POINT_BITS-1:0]           point_index_o;
  logic signed [arm_pv_pkg::VELOCITY_BITS-1:0] vel_x_o, vel_y_o, vel_z_o;
  logic                                        last_point_o;

  point_vel_t expected_vels[$];
  int         mismatches;
  int         cycles;

  arm_point_velocities dut (.*);

  // clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // abandon a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // sine in Q14 of a 32-bit phase, odd polynomial in Q30
  function automatic longint sine_q14(input logic [31:0] ph);
    longint unsigned f, x, x2, s, v;
    longint          res;
    f  = 64'(ph[29:0]);
    x  = ph[30] ? ((64'd1 << 30) - f) : f;
    x2 = (x * x) >> 30;
    s  = 64'(arm_pv_pkg::SIN_C9);
    s  = 64'(arm_pv_pkg::SIN_C7) - ((x2 * s) >> 30);
    s  = 64'(arm_pv_pkg::SIN_C5) - ((x2 * s) >> 30);
    s  = 64'(arm_pv_pkg::SIN_C3) - ((x2 * s) >> 30);
    s  = 64'(arm_pv_pkg::SIN_C1) - ((x2 * s) >> 30);
    v  = (x * s) >> 30;
    if (v > (64'd1 << 30)) v = 64'd1 << 30;
    res = longint'((v + 64'd32768) >> 16);
    return ph[31] ? -res : res;
  endfunction

  // shift right, rounding half up
  function automatic longint round_sh(input longint v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [arm_pv_pkg::VELOCITY_BITS-1:0] clamp_vel(input longint v);
    longint hi, lo;
    hi = (64'sd1 <<< (arm_pv_pkg::VELOCITY_BITS - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[arm_pv_pkg::VELOCITY_BITS-1:0];
  endfunction

  // predict the seven point velocities of one joint sample
  task automatic predict_points(input logic [arm_pv_pkg::ANGLE_BITS-1:0] a1, a2, a3, a4, a5,
                                input logic signed [arm_pv_pkg::RATE_BITS-1:0] r1, r2, r3,
                                r4, r5);
    longint reach_a[6], reach_b[6], side[6];
    logic [arm_pv_pkg::ANGLE_BITS-1:0] a23, a234;
    longint s1, c1, s2, c2, sa, ca, sb, cb, s5, c5;
    longint u1, u2, w23, w234, u5, cbs5, sbs5, cbc5, sbc5;
    longint la, lb, r38, d38, dr, dd, dz, r30, d30, a30, b30;
    point_vel_t pv;
    reach_a = '{0, arm_pv_pkg::LEN_2125, arm_pv_pkg::LEN_425, arm_pv_pkg::LEN_425,
                arm_pv_pkg::LEN_425, arm_pv_pkg::LEN_425};
    reach_b = '{0, 0, 0, arm_pv_pkg::LEN_1294, arm_pv_pkg::LEN_2589, arm_pv_pkg::LEN_39225};
    side    = '{arm_pv_pkg::LEN_0679, arm_pv_pkg::LEN_13585, arm_pv_pkg::LEN_08405,
                arm_pv_pkg::LEN_01615, arm_pv_pkg::LEN_01615, arm_pv_pkg::LEN_06265};
    a23  = a2 + a3;
    a234 = a2 + a3 + a4;
    s1 = sine_q14({a1, 16'd0});   c1 = sine_q14({a1 + arm_pv_pkg::QUARTER_TURN, 16'd0});
    s2 = sine_q14({a2, 16'd0});   c2 = sine_q14({a2 + arm_pv_pkg::QUARTER_TURN, 16'd0});
    sa = sine_q14({a23, 16'd0});  ca = sine_q14({a23 + arm_pv_pkg::QUARTER_TURN, 16'd0});
    sb = sine_q14({a234, 16'd0}); cb = sine_q14({a234 + arm_pv_pkg::QUARTER_TURN, 16'd0});
    s5 = sine_q14({a5, 16'd0});   c5 = sine_q14({a5 + arm_pv_pkg::QUARTER_TURN, 16'd0});
    u1 = r1; u2 = r2; u5 = r5;
    w23  = u2 + longint'(r3);
    w234 = w23 + longint'(r4);
    cbs5 = round_sh(cb * s5, 14);
    sbs5 = round_sh(sb * s5, 14);
    cbc5 = round_sh(cb * c5, 14);
    sbc5 = round_sh(sb * c5, 14);
    for (int k = 0; k < 7; k++) begin
      if (k < 6) begin
        la  = reach_a[k];
        lb  = reach_b[k];
        r38 = la * c2 + lb * ca;
        d38 = side[k] * 16384;
        dr  = -(la * s2 * u2 + lb * sa * w23);
        dd  = 0;
        dz  = -(la * c2 * u2 + lb * ca * w23);
      end else begin
        r38 = longint'(arm_pv_pkg::LEN_425) * c2 + longint'(arm_pv_pkg::LEN_39225) * ca
            - longint'(arm_pv_pkg::LEN_09465) * sb + longint'(arm_pv_pkg::LEN_0411) * cbs5;
        d38 = longint'(arm_pv_pkg::LEN_10915) * 16384 + longint'(arm_pv_pkg::LEN_0411) * c5;
        dr  = -longint'(arm_pv_pkg::LEN_425) * s2 * u2
            - longint'(arm_pv_pkg::LEN_39225) * sa * w23
            - longint'(arm_pv_pkg::LEN_09465) * cb * w234
            - longint'(arm_pv_pkg::LEN_0411) * sbs5 * w234
            + longint'(arm_pv_pkg::LEN_0411) * cbc5 * u5;
        dd  = -longint'(arm_pv_pkg::LEN_0411) * s5 * u5;
        dz  = -longint'(arm_pv_pkg::LEN_425) * c2 * u2
            - longint'(arm_pv_pkg::LEN_39225) * ca * w23
            + longint'(arm_pv_pkg::LEN_09465) * sb * w234
            - longint'(arm_pv_pkg::LEN_0411) * cbs5 * w234
            - longint'(arm_pv_pkg::LEN_0411) * sbc5 * u5;
      end
      r30 = round_sh(r38, 8);
      d30 = round_sh(d38, 8);
      a30 = round_sh(dr, 20) - round_sh(u1 * d30, 12);
      b30 = round_sh(dd, 20) + round_sh(u1 * r30, 12);
      pv.point = k[arm_pv_pkg::POINT_BITS-1:0];
      pv.vx    = clamp_vel(round_sh(c1 * a30 - s1 * b30, 28));
      pv.vy    = clamp_vel(round_sh(s1 * a30 + c1 * b30, 28));
      pv.vz    = clamp_vel(round_sh(dz, 34));
      pv.last  = (pv.point == arm_pv_pkg::POINT_TOOL);
      expected_vels.push_back(pv);
    end
  endtask

  // present one sample and hold it until the block takes the word
  task automatic send_sample(input logic [arm_pv_pkg::ANGLE_BITS-1:0] a1, a2, a3, a4, a5,
                             input logic [arm_pv_pkg::RATE_BITS-1:0] r1, r2, r3, r4, r5);
    start     <= 1'b1;
    angle_1_i <= a1; angle_2_i <= a2; angle_3_i <= a3; angle_4_i <= a4; angle_5_i <= a5;
    rate_1_i  <= r1; rate_2_i  <= r2; rate_3_i  <= r3; rate_4_i  <= r4; rate_5_i  <= r5;
    do @(posedge clk_i); while (busy);
    predict_points(a1, a2, a3, a4, a5, r1, r2, r3, r4, r5);
  endtask

  // drop start and let the requested gap pass; nothing to do for an empty gap
  task automatic idle_cycles(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // field value biased towards the extremes
  function automatic logic [15:0] pick_field();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      4: return 16'h4000 ^ 16'($urandom_range(0, 3) << 14);
      default: return 16'($urandom);
    endcase
  endfunction

  // check each output word against the oldest prediction
  always @(posedge clk_i) begin
    point_vel_t want;
    if (rst_ni && valid_o) begin
      if (expected_vels.size() == 0) begin
        if (mismatches < 10) $display("unexpected word: point %0d", point_index_o);
        mismatches++;
      end else begin
        want = expected_vels.pop_front();
        if (point_index_o !== want.point || vel_x_o !== want.vx || vel_y_o !== want.vy ||
            vel_z_o !== want.vz || last_point_o !== want.last) begin
          if (mismatches < 10)
            $display("mismatch: got pt %0d v %0d %0d %0d l %0b, want pt %0d v %0d %0d %0d l %0b",
                     point_index_o, vel_x_o, vel_y_o, vel_z_o, last_point_o,
                     want.point, want.vx, want.vy, want.vz, want.last);
          mismatches++;
        end
      end
    end
  end

  // extremes, quarter turns, saturation and back-to-back samples
  task automatic test_directed();
    send_sample(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    idle_cycles(3);
    send_sample(16'h4000, 16'hC000, 16'h4000, 16'hC000, 16'h4000,
                16'h1000, 16'hF000, 16'h1000, 16'hF000, 16'h1000);
    send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_sample(16'h2000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h6000,
                16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000);
    idle_cycles(1);
    send_sample(0, 16'h4000, 16'h4000, 16'h4000, 0,
                16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF);
    for (int i = 0; i < 12; i++)
      send_sample(pick_field(), pick_field(), pick_field(), pick_field(), pick_field(),
                  pick_field(), pick_field(), pick_field(), pick_field(), pick_field());
    idle_cycles(2);
  endtask

  // random samples in bursts with random gaps
  task automatic test_random();
    int sent;
    int burst;
    sent = 0;
    while (sent < N_RANDOM) begin
      burst = $urandom_range(1, 20);
      for (int i = 0; i < burst && sent < N_RANDOM; i++) begin
        send_sample(pick_field(), pick_field(), pick_field(), pick_field(), pick_field(),
                    pick_field(), pick_field(), pick_field(), pick_field(), pick_field());
        sent++;
        if ($urandom_range(0, 5) == 0) idle_cycles($urandom_range(1, 8));
      end
      idle_cycles($urandom_range(0, 15));
    end
  endtask

  initial begin
    rst_ni     = 1'b0;
    start      = 1'b0;
    cycles     = 0;
    mismatches = 0;
    {angle_1_i, angle_2_i, angle_3_i, angle_4_i, angle_5_i} = '0;
    {rate_1_i, rate_2_i, rate_3_i, rate_4_i, rate_5_i}      = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random();
    start <= 1'b0;
    // drain outstanding words, then watch for strays
    while (expected_vels.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
